// ===== src/slpd_pkg.sv =====
// ============================================================================
// Serial link packet deframer - shared definitions
// Phase codes, frame constants and the result record of the deframer.
// ============================================================================
package slpd_pkg;

    // Sync word "32BL", first byte in the lowest bits
    localparam logic [31:0] SYNC_WORD = 32'h4C42_3233;
    // Tags "MLTI" and "USER", first byte in the lowest bits
    localparam logic [31:0] TAG_MLTI  = 32'h4954_4C4D;
    localparam logic [31:0] TAG_USER  = 32'h5245_5355;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned LEN_W     = 16;
    localparam int unsigned HDR_CNT_W = 3;
    localparam int unsigned TAG_KEEP  = 3;
    localparam int unsigned REPLY_W   = 2;
    localparam int unsigned OUT_TDATA_W = 16;

    localparam logic [REPLY_W-1:0] REPLY_ENABLED  = 2'd2;
    localparam logic [REPLY_W-1:0] REPLY_DISABLED = 2'd0;

    // Receive phase, one-hot
    typedef enum logic [4:0] {
        PH_HEADER  = 5'b00001,
        PH_FLAG    = 5'b00010,
        PH_LEN_LO  = 5'b00100,
        PH_LEN_HI  = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } t_phase;

    // One result item
    typedef struct packed {
        logic               payload_valid;
        logic [BYTE_W-1:0]  payload_byte;
        logic               payload_last;
        logic               empty_message;
        logic               reply_request;
        logic [REPLY_W-1:0] reply_value;
        logic               tag_rejected;
        logic               peer_up;
        logic               link_connected;
    } t_result;

endpackage

// ===== src/serial_link_packet_deframer.sv =====
// ============================================================================
// Serial link packet deframer
// Frames a received byte stream into handshake and user message events.
// ============================================================================
// Usage:
//   Input stream (s_axis_*): one transfer per received byte (tuser = 0,
//   tdata = byte) or per link-down event (tuser = 1). Each accepted transfer
//   produces exactly one result transfer on the output stream (m_axis_*).
//   Bytes are matched against the sync "32BL", then a four-byte tag follows.
//   Tag "MLTI" takes one flag byte and may request a handshake reply; tag
//   "USER" takes a little-endian 16-bit length, then that many payload bytes,
//   the last one marked with tlast. Unknown tags are flagged and dropped.
//   Configuration: one write channel (i_cfg_valid/o_cfg_ready/i_cfg_data)
//   sets multiplayer_enable; write it only while the block is idle.
//   Output: each result is registered in the output register or skid entry.
//   Throughput: one item per cycle while s_axis_tready is high; all per-byte
//   work is one compare/count step from input handshake to result register.
//   Reset: phase returns to sync matching, peer flag and enable clear, the
//   output buffer empties.
//   Stall: a two-entry output buffer holds results while m_axis_tready is
//   low; s_axis_tready drops only once both entries are full.
// ============================================================================
module serial_link_packet_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,      // [0] multiplayer_enable
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] rx_byte
    input  logic        s_axis_tuser,    // [0] kind
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] payload_valid, [8:1] payload_byte, [9] empty_message,
    // [10] reply_request, [12:11] reply_value, [13] tag_rejected,
    // [14] peer_up, [15] link_connected
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tlast     // payload_last
);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    logic                                  r_enable;
    slpd_pkg::t_phase                      r_phase, n_phase;
    logic [slpd_pkg::HDR_CNT_W-1:0]        r_hdr_cnt, n_hdr_cnt;
    logic [slpd_pkg::BYTE_W-1:0]           r_tag [slpd_pkg::TAG_KEEP];
    logic [slpd_pkg::BYTE_W-1:0]           r_len_lo;
    logic [slpd_pkg::LEN_W-1:0]            r_msg_len;
    logic [slpd_pkg::LEN_W-1:0]            r_pay_cnt, n_pay_cnt;
    logic                                  r_peer, n_peer;

    slpd_pkg::t_result                     r_out, r_skid, res;
    logic                                  r_out_valid, n_out_valid;
    logic                                  r_skid_valid, n_skid_valid;

    logic                                  in_xfer, out_xfer, cfg_xfer;
    logic                                  tag_wr;
    logic [slpd_pkg::BYTE_W-1:0]           rx_b;
    logic [31:0]                           tag_word;
    logic [slpd_pkg::BYTE_W-1:0]           sync_b;

    assign o_cfg_ready   = 1'b1;
    assign cfg_xfer      = i_cfg_valid && o_cfg_ready;
    assign s_axis_tready = !r_skid_valid;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_xfer      = r_out_valid && m_axis_tready;
    assign rx_b          = s_axis_tdata;
    assign tag_word      = {rx_b, r_tag[2], r_tag[1], r_tag[0]};
    assign sync_b        = slpd_pkg::SYNC_WORD[r_hdr_cnt[1:0]*slpd_pkg::BYTE_W +: slpd_pkg::BYTE_W];

    // ------------------------------------------------------------------
    // Per-item framing step
    // ------------------------------------------------------------------
    always_comb begin
        n_phase   = r_phase;
        n_hdr_cnt = r_hdr_cnt;
        n_pay_cnt = r_pay_cnt;
        n_peer    = r_peer;
        tag_wr    = 1'b0;
        res       = '0;
        if (s_axis_tuser) begin
            // link down: drop peer, keep framing
            n_peer = 1'b0;
        end else begin
            unique case (r_phase)
                slpd_pkg::PH_FLAG: begin
                    n_peer = (rx_b != '0);
                    if (rx_b != '0) begin
                        res.reply_request = 1'b1;
                        res.reply_value   = r_enable ? slpd_pkg::REPLY_ENABLED
                                                     : slpd_pkg::REPLY_DISABLED;
                    end
                    n_phase   = slpd_pkg::PH_HEADER;
                    n_hdr_cnt = '0;
                end
                slpd_pkg::PH_LEN_LO: begin
                    n_phase = slpd_pkg::PH_LEN_HI;
                end
                slpd_pkg::PH_LEN_HI: begin
                    n_pay_cnt = '0;
                    if ({rx_b, r_len_lo} == '0) begin
                        res.empty_message = 1'b1;
                        n_phase           = slpd_pkg::PH_HEADER;
                        n_hdr_cnt         = '0;
                    end else begin
                        n_phase = slpd_pkg::PH_PAYLOAD;
                    end
                end
                slpd_pkg::PH_PAYLOAD: begin
                    res.payload_valid = 1'b1;
                    res.payload_byte  = rx_b;
                    n_pay_cnt         = r_pay_cnt + 1'b1;
                    if (n_pay_cnt >= r_msg_len) begin
                        res.payload_last = 1'b1;
                        n_phase          = slpd_pkg::PH_HEADER;
                        n_hdr_cnt        = '0;
                    end
                end
                slpd_pkg::PH_HEADER: begin
                    if (!r_hdr_cnt[2]) begin
                        // sync match; a mismatching byte is not retried
                        n_hdr_cnt = (rx_b == sync_b) ? r_hdr_cnt + 1'b1 : '0;
                    end else if (r_hdr_cnt[1:0] != 2'd3) begin
                        tag_wr    = 1'b1;
                        n_hdr_cnt = r_hdr_cnt + 1'b1;
                    end else begin
                        // fourth tag byte: decode the tag
                        n_hdr_cnt = '0;
                        if (tag_word == slpd_pkg::TAG_MLTI) begin
                            n_phase = slpd_pkg::PH_FLAG;
                        end else if (tag_word == slpd_pkg::TAG_USER) begin
                            n_phase = slpd_pkg::PH_LEN_LO;
                        end else begin
                            res.tag_rejected = 1'b1;
                        end
                    end
                end
                default: begin
                    n_phase   = slpd_pkg::PH_HEADER;
                    n_hdr_cnt = '0;
                end
            endcase
        end
        res.peer_up        = n_peer;
        res.link_connected = n_peer && r_enable;
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= 1'b0;
            r_phase   <= slpd_pkg::PH_HEADER;
            r_hdr_cnt <= '0;
            r_pay_cnt <= '0;
            r_peer    <= 1'b0;
        end else begin
            if (cfg_xfer) begin
                r_enable <= i_cfg_data;
            end
            if (in_xfer) begin
                r_phase   <= n_phase;
                r_hdr_cnt <= n_hdr_cnt;
                r_pay_cnt <= n_pay_cnt;
                r_peer    <= n_peer;
            end
        end
    end

    // ------------------------------------------------------------------
    // Header and length capture
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_xfer && !s_axis_tuser) begin
            if (tag_wr) begin
                r_tag[r_hdr_cnt[1:0]] <= rx_b;
            end
            if (r_phase == slpd_pkg::PH_LEN_LO) begin
                r_len_lo <= rx_b;
            end
            if (r_phase == slpd_pkg::PH_LEN_HI) begin
                r_msg_len <= {rx_b, r_len_lo};
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register with skid entry
    // ------------------------------------------------------------------
    assign n_out_valid  = in_xfer || r_skid_valid || (r_out_valid && !m_axis_tready);
    assign n_skid_valid = (r_skid_valid && !out_xfer)
                       || (in_xfer && r_out_valid && !m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            if (!r_out_valid || m_axis_tready) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end else if (out_xfer && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out.payload_last;
    assign m_axis_tdata  = {r_out.link_connected, r_out.peer_up, r_out.tag_rejected,
                            r_out.reply_value, r_out.reply_request, r_out.empty_message,
                            r_out.payload_byte, r_out.payload_valid};

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while output register empty");

    a_link_down_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && s_axis_tuser) |=> !r_peer)
        else $error("peer flag survived a link-down event");

    a_last_is_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.payload_last) |-> r_out.payload_valid)
        else $error("last marker on a non-payload result");

    a_connected_needs_peer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.link_connected) |-> (r_out.peer_up && r_enable))
        else $error("link connected without peer or enable");

endmodule

// ===== tb/sv/serial_link_packet_deframer_tb.sv =====
// ============================================================================
// Serial link packet deframer - testbench
// Sends framed byte streams and link-down events into the deframer and checks
// every result transfer against a cycle-free model of the framing logic.
// Directed frames run first, then random ones (handshakes, user messages,
// rejected tags, broken sync and noise). Random idling and stalls are applied
// on both streams, and multiplayer_enable is changed between phases.
// ============================================================================
module serial_link_packet_deframer_tb;

    // Track framing state and hold the expected result of every accepted byte
    class deframer_scoreboard;
        slpd_pkg::t_result              expected_q[$];
        bit                             enable;
        slpd_pkg::t_phase               phase;
        logic [3:0]                     hdr_count;
        logic [31:0]                    tag_seen;
        logic [7:0]                     len_low;
        logic [slpd_pkg::LEN_W-1:0]     msg_len;
        logic [slpd_pkg::LEN_W-1:0]     byte_count;
        bit                             peer;
        int                             errors;

        function new();
            enable     = 1'b0;
            phase      = slpd_pkg::PH_HEADER;
            hdr_count  = '0;
            tag_seen   = '0;
            len_low    = '0;
            msg_len    = '0;
            byte_count = '0;
            peer       = 1'b0;
            errors     = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Advance the framing state for one accepted input transfer
        function void note_item(bit kind, logic [7:0] b);
            slpd_pkg::t_result r;
            r = '0;
            if (kind) begin
                peer = 1'b0;
            end else begin
                case (phase)
                    slpd_pkg::PH_FLAG: begin
                        peer = (b != 8'd0);
                        if (peer) begin
                            r.reply_request = 1'b1;
                            r.reply_value   = enable ? slpd_pkg::REPLY_ENABLED
                                                     : slpd_pkg::REPLY_DISABLED;
                        end
                        phase     = slpd_pkg::PH_HEADER;
                        hdr_count = '0;
                    end
                    slpd_pkg::PH_LEN_LO: begin
                        len_low = b;
                        phase   = slpd_pkg::PH_LEN_HI;
                    end
                    slpd_pkg::PH_LEN_HI: begin
                        msg_len    = {b, len_low};
                        byte_count = '0;
                        if (msg_len == '0) begin
                            r.empty_message = 1'b1;
                            phase           = slpd_pkg::PH_HEADER;
                            hdr_count       = '0;
                        end else begin
                            phase = slpd_pkg::PH_PAYLOAD;
                        end
                    end
                    slpd_pkg::PH_PAYLOAD: begin
                        r.payload_valid = 1'b1;
                        r.payload_byte  = b;
                        byte_count      = byte_count + 1'b1;
                        if (byte_count >= msg_len) begin
                            r.payload_last = 1'b1;
                            phase          = slpd_pkg::PH_HEADER;
                            hdr_count      = '0;
                        end
                    end
                    default: begin
                        phase = slpd_pkg::PH_HEADER;
                        if (hdr_count < 4) begin
                            // a mismatching byte is dropped, not taken as a new start
                            if (b == slpd_pkg::SYNC_WORD[8*hdr_count +: 8])
                                hdr_count = hdr_count + 1'b1;
                            else
                                hdr_count = '0;
                        end else begin
                            tag_seen[8*hdr_count[1:0] +: 8] = b;
                            hdr_count = hdr_count + 1'b1;
                            if (hdr_count >= 8) begin
                                if (tag_seen == slpd_pkg::TAG_MLTI) begin
                                    phase = slpd_pkg::PH_FLAG;
                                end else if (tag_seen == slpd_pkg::TAG_USER) begin
                                    phase = slpd_pkg::PH_LEN_LO;
                                end else begin
                                    r.tag_rejected = 1'b1;
                                    hdr_count      = '0;
                                end
                            end
                        end
                    end
                endcase
            end
            r.peer_up        = peer;
            r.link_connected = enable & peer;
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned exp_val, int unsigned act_val);
            if (exp_val != act_val) begin
                $error("%s: expected %0h, got %0h", name, exp_val, act_val);
                errors++;
            end
        endfunction

        // Compare one result transfer with the oldest expectation
        function void check_result(logic [slpd_pkg::OUT_TDATA_W-1:0] data, logic last);
            slpd_pkg::t_result exp_r;
            if (expected_q.size() == 0) begin
                $error("result transfer with no expectation pending: tdata %0h", data);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            compare_field("payload_valid", exp_r.payload_valid, data[0]);
            compare_field("payload_byte", exp_r.payload_byte, data[8:1]);
            compare_field("payload_last", exp_r.payload_last, last);
            compare_field("empty_message", exp_r.empty_message, data[9]);
            compare_field("reply_request", exp_r.reply_request, data[10]);
            compare_field("reply_value", exp_r.reply_value, data[12:11]);
            compare_field("tag_rejected", exp_r.tag_rejected, data[13]);
            compare_field("peer_up", exp_r.peer_up, data[14]);
            compare_field("link_connected", exp_r.link_connected, data[15]);
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data    = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;   // [7:0] rx_byte
    logic        s_axis_tuser  = 1'b0;   // [0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [0] payload_valid, [8:1] payload_byte, [9] empty_message,
    // [10] reply_request, [12:11] reply_value, [13] tag_rejected,
    // [14] peer_up, [15] link_connected
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;           // payload_last

    deframer_scoreboard board = new();

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int linkdown_pct   = 0;
    int items_sent     = 0;

    serial_link_packet_deframer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    // Check result transfers and stall the output stream at random
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata, m_axis_tlast);
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Send one input transfer, idling at random before it
    task automatic send_item(bit kind, logic [7:0] b);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        board.note_item(kind, b);
        items_sent++;
    endtask

    // Send a received byte, sometimes preceded by a link-down event
    task automatic send_byte(logic [7:0] b);
        if ($urandom_range(0, 99) < linkdown_pct)
            send_item(1'b1, 8'($urandom_range(0, 255)));
        send_item(1'b0, b);
    endtask

    task automatic send_word(logic [31:0] w);
        for (int i = 0; i < 4; i++)
            send_byte(w[8*i +: 8]);
    endtask

    task automatic send_user(int unsigned len);
        send_word(slpd_pkg::SYNC_WORD);
        send_word(slpd_pkg::TAG_USER);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        for (int unsigned i = 0; i < len; i++)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_mlti(logic [7:0] flag);
        send_word(slpd_pkg::SYNC_WORD);
        send_word(slpd_pkg::TAG_MLTI);
        send_byte(flag);
    endtask

    // Hold the input idle until every expected result has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_enable(bit value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        board.enable = value;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Pick one random sequence: mostly well-formed frames, some broken ones
    task automatic send_random_frame();
        int          sel;
        int          n;
        logic [31:0] tag_word;
        logic [7:0]  b;
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            send_user(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24));
        end else if (sel < 65) begin
            n = $urandom_range(0, 2);
            send_mlti((n == 0) ? 8'h00 : (n == 1) ? 8'hFF : 8'($urandom_range(1, 255)));
        end else if (sel < 75) begin
            // unknown tag: fully random or one byte off a known tag
            if ($urandom_range(0, 1)) begin
                tag_word = $urandom();
            end else begin
                tag_word = $urandom_range(0, 1) ? slpd_pkg::TAG_MLTI : slpd_pkg::TAG_USER;
                tag_word[8*$urandom_range(0, 3) +: 8] ^= 8'($urandom_range(1, 255));
            end
            if (tag_word == slpd_pkg::TAG_MLTI || tag_word == slpd_pkg::TAG_USER)
                tag_word = ~tag_word;
            send_word(slpd_pkg::SYNC_WORD);
            send_word(tag_word);
        end else if (sel < 87) begin
            // partial sync, then a wrong byte (often the first sync byte)
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++)
                send_byte(slpd_pkg::SYNC_WORD[8*i +: 8]);
            if (n > 0 && $urandom_range(0, 1)) begin
                b = slpd_pkg::SYNC_WORD[7:0];
            end else begin
                b = 8'($urandom_range(0, 255));
                while (b == slpd_pkg::SYNC_WORD[8*n +: 8])
                    b = 8'($urandom_range(0, 255));
            end
            send_byte(b);
        end else begin
            // line noise, then a byte that breaks any partial sync
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                send_byte(8'($urandom_range(0, 255)));
            send_byte(8'h00);
        end
    endtask

    initial begin
        int src_pct[4];
        int sink_pct[4];
        int target;
        src_pct  = '{0, 79, 0, 31};
        sink_pct = '{0, 0, 79, 31};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_enable(1'b1);

        // Sync mismatch: the second first-sync byte is dropped, not rechecked
        send_item(1'b0, slpd_pkg::SYNC_WORD[7:0]);
        send_item(1'b0, slpd_pkg::SYNC_WORD[7:0]);
        // Handshake with a link-down event in the middle of the header
        send_word(slpd_pkg::SYNC_WORD);
        send_item(1'b1, 8'hFF);
        send_word(slpd_pkg::TAG_MLTI);
        send_item(1'b0, 8'hFF);
        // Zero-length user message
        send_word(slpd_pkg::SYNC_WORD);
        send_word(slpd_pkg::TAG_USER);
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'h00);
        drain();

        for (int p = 0; p < 4; p++) begin
            drain();
            src_idle_pct   = src_pct[p];
            sink_stall_pct = sink_pct[p];
            linkdown_pct   = 3;
            write_enable(p[0]);
            target = items_sent + 440;
            // one long message, length above one byte
            if (p == 0)
                send_user(16'h0100 + $urandom_range(0, 40));
            while (items_sent < target)
                send_random_frame();
        end
        drain();
        repeat (4) @(posedge i_clk);

        if (board.errors == 0 && board.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // End a hung run
    initial begin
        #(12 * 600000);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
